// File: hdl/mips_pkg.sv
// Package for the MIPS32 instruction executor: opcodes, funct codes, sizes,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package mips_pkg;

    localparam int DATA_BYTES = 4096;
    localparam int MEM_AW     = $clog2(DATA_BYTES);
    localparam logic [31:0] RESET_PC = 32'h0040_0000;
    localparam logic [31:0] EXIT_CODE = 32'h0000_000a;

    // opcodes
    localparam logic [5:0] OP_RTYPE  = 6'h00;
    localparam logic [5:0] OP_REGIMM = 6'h01;
    localparam logic [5:0] OP_J      = 6'h02;
    localparam logic [5:0] OP_JAL    = 6'h03;
    localparam logic [5:0] OP_BEQ    = 6'h04;
    localparam logic [5:0] OP_BNE    = 6'h05;
    localparam logic [5:0] OP_BLEZ   = 6'h06;
    localparam logic [5:0] OP_BGTZ   = 6'h07;
    localparam logic [5:0] OP_ADDI   = 6'h08;
    localparam logic [5:0] OP_ADDIU  = 6'h09;
    localparam logic [5:0] OP_ANDI   = 6'h0c;
    localparam logic [5:0] OP_ORI    = 6'h0d;
    localparam logic [5:0] OP_XORI   = 6'h0e;
    localparam logic [5:0] OP_LUI    = 6'h0f;
    localparam logic [5:0] OP_LB     = 6'h20;
    localparam logic [5:0] OP_LH     = 6'h21;
    localparam logic [5:0] OP_LW     = 6'h23;
    localparam logic [5:0] OP_LBU    = 6'h24;
    localparam logic [5:0] OP_LHU    = 6'h25;
    localparam logic [5:0] OP_SB     = 6'h28;
    localparam logic [5:0] OP_SH     = 6'h29;
    localparam logic [5:0] OP_SW     = 6'h2b;

    // R-type funct
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_SYSC = 6'h0c;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MTHI = 6'h11;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MTLO = 6'h13;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_DIVU = 6'h1b;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    // REGIMM rt
    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    // controller to datapath
    typedef struct packed {
        logic clear_step;   // write zero to clear row, advance clear pointer
        logic latch;        // capture instruction, read operands
        logic decode;       // decode and start multi-cycle work
        logic mem_step;     // run one byte of a load or store
        logic div_step;     // one bit of divide
        logic commit;       // update state, load output register
        logic out_take;     // output register drained
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic need_mem;
        logic mem_last;
        logic need_div;
        logic div_last;
        logic stopped;
    } ctl_sts_t;

endpackage
`default_nettype wire

// File: hdl/mips32_instruction_executor_top.sv
// Top level of the MIPS32 instruction executor; joins mips_ctrl and
// mips_datapath. Uses mips_pkg.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata[31:0] instruction
//  m_       out  m_tvalid/m_tready   m_tdata[104:0] result fields, zero padded to 112
//  cfg      in   cfg_valid/cfg_ready cfg_data[31:0] start_pc
//
// Loads and stores of n bytes go through one memory port, one byte a cycle; a
// nonzero divide runs on a bit-serial divider. After reset a clearing pass
// zeroes all DATA_BYTES bytes of memory before any instruction is taken;
// start_pc writes are taken during it.
// Reset is synchronous, active low. A held result does not block the next
// instruction's capture; commit waits for the output register to be free.
`default_nettype none
module mips32_instruction_executor_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] instruction
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] next_pc, [32] halted, [33] illegal, [34] reg_write,
    // [39:35] reg_index, [71:40] reg_value, [72] mem_write, [104:73] mem_address
    output logic [111:0]     m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import mips_pkg::*;

    ctl_cmd_t    cmd;
    ctl_sts_t    sts;
    logic [104:0] res;

    mips_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .cfg_ready, .sts, .cmd
    );

    mips_datapath u_dp (
        .aclk, .aresetn,
        .cfg_valid(cfg_valid && cfg_ready), .cfg_data,
        .instr(s_tdata), .cmd, .sts, .result(res)
    );

    assign m_tdata = {7'h0, res};
endmodule
`default_nettype wire

// File: hdl/mips_datapath.sv
// Datapath of the MIPS32 executor: register file, HI/LO, PC, byte memory,
// serial divider and the output register. Uses mips_pkg.
`default_nettype none
module mips_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic [31:0]         cfg_data,
    input  wire logic [31:0]         instr,
    input  wire mips_pkg::ctl_cmd_t  cmd,
    output mips_pkg::ctl_sts_t       sts,
    output logic [104:0]             result
);
    import mips_pkg::*;

    logic [31:0] pc_reg, hi_reg, lo_reg;
    logic        stop_reg;
    logic [31:0] rf [32];
    logic [7:0]  dmem [DATA_BYTES];
    logic [31:0] ir_reg, a_reg, b_reg, r2_reg;
    logic [MEM_AW:0] clr_reg;

    // clear pass over the memory after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (cmd.clear_step) clr_reg <= clr_reg + 1'b1;
    end
    assign sts.clear_done = clr_reg[MEM_AW];

    // decode fields
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh;
    logic [31:0] imm, simm, seq, btarget, ea;
    assign op = ir_reg[31:26];
    assign rs = ir_reg[25:21];
    assign rt = ir_reg[20:16];
    assign rd = ir_reg[15:11];
    assign sh = ir_reg[10:6];
    assign fn = ir_reg[5:0];
    assign imm = {16'h0, ir_reg[15:0]};
    assign simm = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign seq = pc_reg + 32'd4;
    assign btarget = seq + {simm[29:0], 2'b00};
    assign ea = a_reg + simm;

    // combinational execute (loads and divides use the registered unit results)
    logic        wen, ill, mw, halt, neg, hi_we, lo_we;
    logic [4:0]  widx;
    logic [31:0] wval, npc, nhi, nlo, maddr;
    logic [2:0]  nbytes;
    logic        is_load, is_store, is_div;
    logic [63:0] prod_s, prod_u;
    logic [31:0] ldv_reg, q_reg, r_reg;
    logic        na_reg, nb_reg, sdiv_reg;
    logic [2:0]  mcnt_reg;
    logic [5:0]  dcnt_reg;
    logic [31:0] dd_reg, dv_reg;

    assign prod_s = $signed({{32{a_reg[31]}}, a_reg}) * $signed({{32{b_reg[31]}}, b_reg});
    assign prod_u = {32'h0, a_reg} * {32'h0, b_reg};

    always_comb begin
        wen = 1'b0; ill = 1'b0; mw = 1'b0; halt = 1'b0;
        widx = 5'd0; wval = 32'h0; npc = seq; nhi = hi_reg; nlo = lo_reg;
        maddr = 32'h0; nbytes = 3'd0; is_load = 1'b0; is_store = 1'b0; is_div = 1'b0;
        hi_we = 1'b0; lo_we = 1'b0;
        neg = a_reg[31];
        case (op)
            OP_RTYPE: begin
                case (fn)
                    FN_SLL:  begin wen = 1'b1; widx = rd; wval = b_reg << sh; end
                    FN_SRL:  begin wen = 1'b1; widx = rd; wval = b_reg >> sh; end
                    FN_SRA:  begin wen = 1'b1; widx = rd; wval = $signed(b_reg) >>> sh; end
                    FN_SLLV: begin wen = 1'b1; widx = rd; wval = b_reg << a_reg[4:0]; end
                    FN_SRLV: begin wen = 1'b1; widx = rd; wval = b_reg >> a_reg[4:0]; end
                    FN_SRAV: begin
                        wen = 1'b1; widx = rd; wval = $signed(b_reg) >>> a_reg[4:0];
                    end
                    FN_JR:   npc = a_reg;
                    FN_JALR: begin wen = 1'b1; widx = rd; wval = seq; npc = a_reg; end
                    FN_SYSC: if (r2_reg == EXIT_CODE) begin halt = 1'b1; npc = pc_reg; end
                    FN_MFHI: begin wen = 1'b1; widx = rd; wval = hi_reg; end
                    FN_MTHI: nhi = a_reg;
                    FN_MFLO: begin wen = 1'b1; widx = rd; wval = lo_reg; end
                    FN_MTLO: nlo = a_reg;
                    FN_MULT: begin nhi = prod_s[63:32]; nlo = prod_s[31:0]; end
                    FN_MULTU: begin nhi = prod_u[63:32]; nlo = prod_u[31:0]; end
                    FN_DIV, FN_DIVU: begin
                        is_div = (b_reg != 32'h0);
                        if (is_div) begin
                            nlo = (sdiv_reg && (na_reg != nb_reg)) ? -q_reg : q_reg;
                            nhi = (sdiv_reg && na_reg) ? -r_reg : r_reg;
                        end
                    end
                    FN_ADD, FN_ADDU: begin wen = 1'b1; widx = rd; wval = a_reg + b_reg; end
                    FN_SUB, FN_SUBU: begin wen = 1'b1; widx = rd; wval = a_reg - b_reg; end
                    FN_AND: begin wen = 1'b1; widx = rd; wval = a_reg & b_reg; end
                    FN_OR:  begin wen = 1'b1; widx = rd; wval = a_reg | b_reg; end
                    FN_XOR: begin wen = 1'b1; widx = rd; wval = a_reg ^ b_reg; end
                    FN_NOR: begin wen = 1'b1; widx = rd; wval = ~(a_reg | b_reg); end
                    FN_SLT: begin
                        wen = 1'b1; widx = rd;
                        wval = {31'h0, $signed(a_reg) < $signed(b_reg)};
                    end
                    FN_SLTU: begin wen = 1'b1; widx = rd; wval = {31'h0, a_reg < b_reg}; end
                    default: ill = 1'b1;
                endcase
            end
            OP_REGIMM: begin
                case (rt)
                    RI_BLTZ: npc = neg ? btarget : seq;
                    RI_BGEZ: npc = neg ? seq : btarget;
                    RI_BLTZAL: begin
                        wen = 1'b1; widx = 5'd31; wval = seq; npc = neg ? btarget : seq;
                    end
                    RI_BGEZAL: begin
                        wen = 1'b1; widx = 5'd31; wval = seq; npc = neg ? seq : btarget;
                    end
                    default: ill = 1'b1;
                endcase
            end
            OP_J:   npc = {seq[31:28], ir_reg[25:0], 2'b00};
            OP_JAL: begin
                wen = 1'b1; widx = 5'd31; wval = seq;
                npc = {seq[31:28], ir_reg[25:0], 2'b00};
            end
            OP_BEQ: npc = (a_reg == b_reg) ? btarget : seq;
            OP_BNE: npc = (a_reg != b_reg) ? btarget : seq;
            OP_BLEZ: begin
                if (rt != 5'd0) ill = 1'b1;
                else npc = (neg || a_reg == 32'h0) ? btarget : seq;
            end
            OP_BGTZ: begin
                if (rt != 5'd0) ill = 1'b1;
                else npc = (!neg && a_reg != 32'h0) ? btarget : seq;
            end
            OP_ADDI, OP_ADDIU: begin wen = 1'b1; widx = rt; wval = a_reg + simm; end
            OP_ANDI: begin wen = 1'b1; widx = rt; wval = a_reg & imm; end
            OP_ORI:  begin wen = 1'b1; widx = rt; wval = a_reg | imm; end
            OP_XORI: begin wen = 1'b1; widx = rt; wval = a_reg ^ imm; end
            OP_LUI: begin
                if (rs != 5'd0) ill = 1'b1;
                else begin wen = 1'b1; widx = rt; wval = {ir_reg[15:0], 16'h0}; end
            end
            OP_LB: begin
                is_load = 1'b1; nbytes = 3'd1; maddr = ea; wen = 1'b1; widx = rt;
                wval = {{24{ldv_reg[7]}}, ldv_reg[7:0]};
            end
            OP_LBU: begin
                is_load = 1'b1; nbytes = 3'd1; maddr = ea; wen = 1'b1; widx = rt;
                wval = {24'h0, ldv_reg[7:0]};
            end
            OP_LH: begin
                is_load = 1'b1; nbytes = 3'd2; maddr = ea; wen = 1'b1; widx = rt;
                wval = {{16{ldv_reg[15]}}, ldv_reg[15:0]};
            end
            OP_LHU: begin
                is_load = 1'b1; nbytes = 3'd2; maddr = ea; wen = 1'b1; widx = rt;
                wval = {16'h0, ldv_reg[15:0]};
            end
            OP_LW: begin
                is_load = 1'b1; nbytes = 3'd4; maddr = ea; wen = 1'b1; widx = rt;
                wval = ldv_reg;
            end
            OP_SB: begin is_store = 1'b1; nbytes = 3'd1; maddr = ea; mw = 1'b1; end
            OP_SH: begin is_store = 1'b1; nbytes = 3'd2; maddr = ea; mw = 1'b1; end
            OP_SW: begin is_store = 1'b1; nbytes = 3'd4; maddr = ea; mw = 1'b1; end
            default: ill = 1'b1;
        endcase
        if (widx == 5'd0) begin
            wen = 1'b0; wval = 32'h0;
        end
        if (!wen) widx = 5'd0;
        hi_we = !ill; lo_we = !ill;
    end

    assign sts.need_mem = !ill && (is_load || is_store);
    assign sts.need_div = !ill && is_div;
    assign sts.stopped  = stop_reg;

    // instruction and operand capture
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            ir_reg <= instr;
            a_reg  <= rf[instr[25:21]];
            b_reg  <= rf[instr[20:16]];
            r2_reg <= rf[2];
        end
    end

    // byte-serial memory access, one byte per cycle, little-endian
    logic [31:0]     baddr;
    logic [MEM_AW-1:0] maddr_w;
    logic [7:0]      rbyte_reg;
    logic            rbyte_v_reg;
    logic [2:0]      rbyte_k_reg;
    assign baddr   = ea + {29'h0, mcnt_reg};
    assign maddr_w = cmd.clear_step ? clr_reg[MEM_AW-1:0] : baddr[MEM_AW-1:0];
    assign sts.mem_last = (mcnt_reg == nbytes - 3'd1);

    always_ff @(posedge aclk) begin
        if (cmd.clear_step || (cmd.mem_step && is_store))
            dmem[maddr_w] <= cmd.clear_step ? 8'h00 : b_reg[{mcnt_reg[1:0], 3'b000} +: 8];
        rbyte_reg <= dmem[maddr_w];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcnt_reg <= '0; rbyte_v_reg <= 1'b0;
        end else begin
            rbyte_v_reg <= cmd.mem_step && is_load;
            rbyte_k_reg <= mcnt_reg;
            if (cmd.decode || cmd.commit) mcnt_reg <= '0;
            else if (cmd.mem_step) mcnt_reg <= mcnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode) ldv_reg <= '0;
        else if (rbyte_v_reg) ldv_reg[{rbyte_k_reg[1:0], 3'b000} +: 8] <= rbyte_reg;
    end

    // restoring divider on magnitudes, one quotient bit per cycle
    logic [32:0] trial;
    assign trial = {r_reg, dd_reg[31]} - {1'b0, dv_reg};
    assign sts.div_last = (dcnt_reg == 6'd31);
    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            sdiv_reg <= (fn == FN_DIV);
            na_reg   <= (fn == FN_DIV) && a_reg[31];
            nb_reg   <= (fn == FN_DIV) && b_reg[31];
            dd_reg   <= ((fn == FN_DIV) && a_reg[31]) ? -a_reg : a_reg;
            dv_reg   <= ((fn == FN_DIV) && b_reg[31]) ? -b_reg : b_reg;
            r_reg    <= '0;
            q_reg    <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dd_reg   <= {dd_reg[30:0], 1'b0};
            dcnt_reg <= dcnt_reg + 6'd1;
            if (!trial[32]) begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                r_reg <= {r_reg[30:0], dd_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= RESET_PC; hi_reg <= '0; lo_reg <= '0; stop_reg <= 1'b0;
        end else if (cfg_valid) begin
            pc_reg <= cfg_data;
        end else if (cmd.commit && !stop_reg && !ill) begin
            pc_reg <= npc;
            if (hi_we) hi_reg <= nhi;
            if (lo_we) lo_reg <= nlo;
            if (halt) stop_reg <= 1'b1;
        end
    end

    // register file, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) rf[i] <= '0;
        end else if (cmd.commit && !stop_reg && !ill && wen) begin
            rf[widx] <= wval;
        end
    end

    // output register: {mem_address, mem_write, reg_value, reg_index, reg_write,
    // illegal, halted, next_pc} packed from the low end upward
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (stop_reg)
                result <= {32'h0, 1'b0, 32'h0, 5'd0, 1'b0, 1'b0, 1'b1, pc_reg};
            else if (ill)
                result <= {32'h0, 1'b0, 32'h0, 5'd0, 1'b0, 1'b1, 1'b0, pc_reg};
            else
                result <= {maddr, mw, wval, widx, wen, 1'b0, halt, npc};
        end
    end

    // a divide never runs past 32 steps
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> dcnt_reg < 6'd32) else $error("divider overran");
    // register zero is never written
    a_r0: assert property (@(posedge aclk) disable iff (!aresetn)
        rf[0] == 32'h0) else $error("r0 nonzero");
    // a halted block keeps its pc on commit
    a_halt_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && stop_reg && !cfg_valid) |=> $stable(pc_reg))
        else $error("pc moved while halted");
endmodule
`default_nettype wire

// File: hdl/mips_ctrl.sv
// Controller of the MIPS32 executor: sequences clear, capture, memory and
// divide steps, commit and output handshake. Uses mips_pkg.
`default_nettype none
module mips_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic                    cfg_ready,
    input  wire mips_pkg::ctl_sts_t sts,
    output mips_pkg::ctl_cmd_t      cmd
);
    import mips_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DEC   = 6'b000100,
        ST_MEM   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg;
    logic   tail_reg;   // set after the last memory step, to land the last load byte

    // the output register parts the sides; commit waits for it instead
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign cfg_ready = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = !sts.clear_done;
                if (sts.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.latch = 1'b1; state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.decode = 1'b1;
                if (sts.stopped) state_next = ST_DONE;
                else if (sts.need_mem) state_next = ST_MEM;
                else if (sts.need_div) state_next = ST_DIV;
                else state_next = ST_DONE;
            end
            ST_MEM: begin
                if (!tail_reg) cmd.mem_step = 1'b1;
                if (tail_reg) state_next = ST_DONE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!ovalid_reg || m_tready) begin
                    cmd.commit = 1'b1; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.out_take = ovalid_reg && m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR; ovalid_reg <= 1'b0; tail_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            tail_reg  <= (state_reg == ST_MEM) && !tail_reg && sts.mem_last;
            if (cmd.commit) ovalid_reg <= 1'b1;
            else if (cmd.out_take) ovalid_reg <= 1'b0;
        end
    end

    // no input is taken before the clearing pass ends
    a_no_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready) else $error("input during clear");
    // a commit never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!ovalid_reg || m_tready)) else $error("result lost");
    // a commit always presents a result next cycle
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid) else $error("result missing");
endmodule
`default_nettype wire

// File: tb/sv/mips_result_checker.sv
// Result checker for the MIPS32 instruction executor: tracks architectural state,
// predicts one result per accepted request and compares it with the m_ channel.
// Depends on mips_pkg.
`default_nettype none
module mips_result_checker
    import mips_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [31:0]  s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [111:0] m_tdata,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [31:0]  cfg_data,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] mem_address;
        logic        mem_write;
        logic [31:0] reg_value;
        logic [4:0]  reg_index;
        logic        reg_write;
        logic        illegal;
        logic        halted;
        logic [31:0] next_pc;
    } exec_result_t;

    // architectural state of the core
    logic [31:0] pc_q;
    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q;
    logic        stopped_q;
    logic [7:0]  dmem [DATA_BYTES];

    exec_result_t retire_q[$];

    function automatic logic [31:0] load_bytes(input logic [31:0] addr, input int n);
        logic [31:0] v;
        logic [31:0] ad;
        v = '0;
        for (int k = 0; k < n; k++) begin
            ad = addr + k;
            v |= 32'(dmem[ad[MEM_AW-1:0]]) << (8 * k);
        end
        return v;
    endfunction

    function automatic void store_bytes(input logic [31:0] addr, input logic [31:0] v,
                                        input int n);
        logic [31:0] ad;
        for (int k = 0; k < n; k++) begin
            ad = addr + k;
            dmem[ad[MEM_AW-1:0]] = v[8*k +: 8];
        end
    endfunction

    // execute one instruction against the tracked state
    function automatic exec_result_t execute(input logic [31:0] inst);
        exec_result_t r;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] imm, simm, a, b, seq, btarget, npc, nhi, nlo, wval, ea, maddr;
        logic [31:0] ma, mb, q, rm, jtarget;
        logic [63:0] prod;
        logic [4:0]  widx;
        logic        wen, ill, mw, halt, neg;
        op = inst[31:26]; rs = inst[25:21]; rt = inst[20:16];
        rd = inst[15:11]; sh = inst[10:6]; fn = inst[5:0];
        imm = {16'h0, inst[15:0]};
        simm = {{16{inst[15]}}, inst[15:0]};
        a = gpr[rs]; b = gpr[rt];
        seq = pc_q + 32'd4;
        btarget = seq + (simm << 2);
        jtarget = {seq[31:28], inst[25:0], 2'b00};
        npc = seq; nhi = hi_q; nlo = lo_q;
        widx = '0; wval = '0; maddr = '0; ea = a + simm;
        wen = 0; ill = 0; mw = 0; halt = 0;
        neg = a[31];
        r = '0;
        if (stopped_q) begin
            r.next_pc = pc_q;
            r.halted = 1'b1;
            return r;
        end
        case (op)
            OP_RTYPE: begin
                case (fn)
                    FN_SLL:  begin wen = 1; widx = rd; wval = b << sh; end
                    FN_SRL:  begin wen = 1; widx = rd; wval = b >> sh; end
                    FN_SRA:  begin wen = 1; widx = rd; wval = $signed(b) >>> sh; end
                    FN_SLLV: begin wen = 1; widx = rd; wval = b << a[4:0]; end
                    FN_SRLV: begin wen = 1; widx = rd; wval = b >> a[4:0]; end
                    FN_SRAV: begin wen = 1; widx = rd; wval = $signed(b) >>> a[4:0]; end
                    FN_JR:   npc = a;
                    FN_JALR: begin wen = 1; widx = rd; wval = seq; npc = a; end
                    FN_SYSC: if (gpr[2] == EXIT_CODE) begin halt = 1; npc = pc_q; end
                    FN_MFHI: begin wen = 1; widx = rd; wval = hi_q; end
                    FN_MTHI: nhi = a;
                    FN_MFLO: begin wen = 1; widx = rd; wval = lo_q; end
                    FN_MTLO: nlo = a;
                    FN_MULT: begin
                        prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                        nhi = prod[63:32]; nlo = prod[31:0];
                    end
                    FN_MULTU: begin
                        prod = {32'h0, a} * {32'h0, b};
                        nhi = prod[63:32]; nlo = prod[31:0];
                    end
                    FN_DIV: if (b != 0) begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb; rm = ma % mb;
                        nlo = (a[31] != b[31]) ? -q : q;
                        nhi = a[31] ? -rm : rm;
                    end
                    FN_DIVU: if (b != 0) begin nlo = a / b; nhi = a % b; end
                    FN_ADD, FN_ADDU: begin wen = 1; widx = rd; wval = a + b; end
                    FN_SUB, FN_SUBU: begin wen = 1; widx = rd; wval = a - b; end
                    FN_AND:  begin wen = 1; widx = rd; wval = a & b; end
                    FN_OR:   begin wen = 1; widx = rd; wval = a | b; end
                    FN_XOR:  begin wen = 1; widx = rd; wval = a ^ b; end
                    FN_NOR:  begin wen = 1; widx = rd; wval = ~(a | b); end
                    FN_SLT:  begin wen = 1; widx = rd; wval = 32'($signed(a) < $signed(b)); end
                    FN_SLTU: begin wen = 1; widx = rd; wval = 32'(a < b); end
                    default: ill = 1;
                endcase
            end
            OP_REGIMM: begin
                case (rt)
                    RI_BLTZ: npc = neg ? btarget : seq;
                    RI_BGEZ: npc = neg ? seq : btarget;
                    RI_BLTZAL: begin
                        wen = 1; widx = 5'd31; wval = seq; npc = neg ? btarget : seq;
                    end
                    RI_BGEZAL: begin
                        wen = 1; widx = 5'd31; wval = seq; npc = neg ? seq : btarget;
                    end
                    default: ill = 1;
                endcase
            end
            OP_J:    npc = jtarget;
            OP_JAL:  begin wen = 1; widx = 5'd31; wval = seq; npc = jtarget; end
            OP_BEQ:  npc = (a == b) ? btarget : seq;
            OP_BNE:  npc = (a != b) ? btarget : seq;
            OP_BLEZ: if (rt != 0) ill = 1; else npc = (neg || a == 0) ? btarget : seq;
            OP_BGTZ: if (rt != 0) ill = 1; else npc = (!neg && a != 0) ? btarget : seq;
            OP_ADDI, OP_ADDIU: begin wen = 1; widx = rt; wval = a + simm; end
            OP_ANDI: begin wen = 1; widx = rt; wval = a & imm; end
            OP_ORI:  begin wen = 1; widx = rt; wval = a | imm; end
            OP_XORI: begin wen = 1; widx = rt; wval = a ^ imm; end
            OP_LUI:  if (rs != 0) ill = 1; else begin wen = 1; widx = rt; wval = imm << 16; end
            OP_LB:  begin
                maddr = ea; wen = 1; widx = rt; wval = load_bytes(ea, 1);
                wval = {{24{wval[7]}}, wval[7:0]};
            end
            OP_LBU: begin maddr = ea; wen = 1; widx = rt; wval = load_bytes(ea, 1); end
            OP_LH:  begin
                maddr = ea; wen = 1; widx = rt; wval = load_bytes(ea, 2);
                wval = {{16{wval[15]}}, wval[15:0]};
            end
            OP_LHU: begin maddr = ea; wen = 1; widx = rt; wval = load_bytes(ea, 2); end
            OP_LW:  begin maddr = ea; wen = 1; widx = rt; wval = load_bytes(ea, 4); end
            OP_SB:  begin maddr = ea; mw = 1; store_bytes(ea, b, 1); end
            OP_SH:  begin maddr = ea; mw = 1; store_bytes(ea, b, 2); end
            OP_SW:  begin maddr = ea; mw = 1; store_bytes(ea, b, 4); end
            default: ill = 1;
        endcase
        if (ill) begin
            r.next_pc = pc_q;
            r.illegal = 1'b1;
            return r;
        end
        // register zero swallows writes
        if (wen && widx == 0) wen = 0;
        if (wen) gpr[widx] = wval;
        hi_q = nhi; lo_q = nlo; pc_q = npc;
        if (halt) stopped_q = 1'b1;
        r.next_pc = npc;
        r.halted = halt;
        r.reg_write = wen;
        r.reg_index = wen ? widx : 5'd0;
        r.reg_value = wen ? wval : 32'd0;
        r.mem_write = mw;
        r.mem_address = maddr;
        return r;
    endfunction

    initial begin
        pc_q = RESET_PC; hi_q = '0; lo_q = '0; stopped_q = 0;
        foreach (gpr[i]) gpr[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        fail_count = 0;
        pending = 0;
    end

    // watch the channels; results are popped before new requests are pushed
    always @(posedge aclk) begin
        exec_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = exec_result_t'(m_tdata);
                got.pad = '0;
                if (retire_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", got);
                end else begin
                    want = retire_q.pop_front();
                    if (got.next_pc != want.next_pc || got.halted != want.halted ||
                        got.illegal != want.illegal || got.reg_write != want.reg_write ||
                        got.reg_index != want.reg_index || got.reg_value != want.reg_value ||
                        got.mem_write != want.mem_write ||
                        got.mem_address != want.mem_address) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready) pc_q = cfg_data;
            if (s_tvalid && s_tready) retire_q.push_back(execute(s_tdata));
            pending <= retire_q.size();
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Top of the MIPS32 instruction executor testbench: clock, reset, instruction
// stimulus, start_pc writes and verdict. Uses mips_pkg and mips_result_checker.
`default_nettype none
module testbench;
    import mips_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [111:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    int           fail_count, pending;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    logic         recv_hold = 0;
    logic         hold_go = 0;
    int           idle_cycles = 0;

    always #2 aclk = ~aclk;

    mips32_instruction_executor_top i_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    mips_result_checker i_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_valid, .cfg_ready, .cfg_data,
        .fail_count, .pending
    );

    // receiver side backpressure
    always @(posedge aclk)
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    // long receiver hold-off so the core fills up and stalls its input
    initial begin
        wait (hold_go);
        @(posedge aclk);
        recv_hold <= 1;
        repeat (400) @(posedge aclk);
        recv_hold <= 0;
    end

    // watchdog on cycles with no request moving anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("mips32_instruction_executor_top regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] r_enc(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sh);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_enc(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // random instruction, mostly legal encodings with random operands
    function automatic logic [31:0] rand_instr();
        logic [5:0] fns [27] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
            FN_JALR, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV,
            FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
            FN_SLT, FN_SLTU, FN_SLL};
        logic [5:0] iops [6] = '{OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI};
        logic [5:0] mops [8] = '{OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW};
        logic [5:0] bops [4] = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
        logic [4:0] ris [4] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL};
        logic [31:0] w;
        logic [4:0]  rs, rt;
        int pick;
        w = $urandom;
        rs = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
        rt = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 30)
            w = r_enc(fns[$urandom_range(26)], rs, rt, w[15:11], w[10:6]);
        else if (pick < 50)
            w = i_enc(iops[$urandom_range(5)], ($urandom_range(4) == 0) ? rs : 5'd0,
                      rt, w[15:0]);
        else if (pick < 70)
            w = i_enc(mops[$urandom_range(7)], rs, rt, w[15:0]);
        else if (pick < 80)
            w = i_enc(bops[$urandom_range(3)], rs, ($urandom_range(3) == 0) ? rt : 5'd0,
                      w[15:0]);
        else if (pick < 86)
            w = i_enc(OP_REGIMM, rs, ($urandom_range(5) == 0) ? 5'($urandom) :
                      ris[$urandom_range(3)], w[15:0]);
        else if (pick < 90)
            w = {($urandom_range(1) == 1) ? OP_JAL : OP_J, w[25:0]};
        // the exit call is issued only at the very end
        if (w[31:26] == OP_RTYPE && w[5:0] == FN_SYSC) w[5:0] = FN_ADDU;
        return w;
    endfunction

    task automatic push_instr(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // start_pc writes happen only with nothing in flight
    task automatic set_start_pc(input logic [31:0] v);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic run_random(input int n);
        repeat (n) push_instr(rand_instr());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // phase 0: directed corners, start_pc at zero
        send_idle_pct <= 9; recv_idle_pct <= 62;
        set_start_pc(32'h0000_0000);
        push_instr(r_enc(FN_SYSC, 0, 0, 0, 0));          // syscall, not the exit code
        push_instr(i_enc(OP_LUI, 0, 1, 16'hffff));
        push_instr(i_enc(OP_ORI, 1, 1, 16'hffff));       // r1 = -1
        push_instr(i_enc(OP_LUI, 0, 3, 16'h8000));       // r3 = most negative
        push_instr(i_enc(OP_ADDIU, 0, 2, 16'h7fff));
        push_instr(r_enc(FN_ADD, 3, 1, 4, 0));           // wraps, no trap
        push_instr(r_enc(FN_SUB, 3, 2, 5, 0));
        push_instr(i_enc(OP_ADDI, 2, 6, 16'h7fff));
        push_instr(r_enc(FN_MULT, 3, 1, 0, 0));
        push_instr(r_enc(FN_MFHI, 0, 0, 6, 0));
        push_instr(r_enc(FN_DIV, 3, 1, 0, 0));           // min / -1
        push_instr(r_enc(FN_MFLO, 0, 0, 7, 0));
        push_instr(r_enc(FN_DIVU, 1, 0, 0, 0));          // divide by zero
        push_instr(r_enc(FN_MFHI, 0, 0, 8, 0));
        push_instr(i_enc(OP_SW, 0, 1, 16'hfffe));        // address wraps around memory
        push_instr(i_enc(OP_LB, 0, 9, 16'hffff));
        push_instr(i_enc(OP_LHU, 3, 10, 16'h0000));
        push_instr(r_enc(FN_SRA, 0, 3, 11, 5'd31));
        push_instr(r_enc(FN_SLTU, 1, 3, 0, 0));          // write to register zero
        push_instr(32'hfc00_0000);                       // unknown opcode
        push_instr(i_enc(OP_BLEZ, 1, 5, 16'h0004));      // rt nonzero
        push_instr(i_enc(OP_LUI, 1, 4, 16'h1234));       // rs nonzero
        push_instr(i_enc(OP_REGIMM, 2, RI_BLTZAL, 16'h8000)); // links, not taken
        push_instr({OP_J, 26'h3ff_ffff});
        push_instr(r_enc(FN_JR, 1, 0, 0, 0));
        run_random(330);

        // phase 1: swapped idling plus a long receiver hold-off
        send_idle_pct <= 62; recv_idle_pct <= 9;
        set_start_pc(32'hffff_ffff);
        hold_go <= 1;
        send_idle_pct <= 0;
        run_random(60);
        send_idle_pct <= 62;
        run_random(290);

        // phase 2: no idling
        send_idle_pct <= 0; recv_idle_pct <= 0;
        set_start_pc($urandom);
        run_random(350);

        // phase 3: top of the address space, then the exit call
        set_start_pc(32'hffff_fffc);
        run_random(300);
        push_instr(i_enc(OP_ADDIU, 0, 2, EXIT_CODE[15:0]));
        push_instr(r_enc(FN_SYSC, 0, 0, 0, 0));
        repeat (5) push_instr(rand_instr());
        s_tvalid <= 0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("mips32_instruction_executor_top regression: pass");
        else
            $display("mips32_instruction_executor_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
